// ===== design/wws_pkg.sv =====
// Shared constants, types and the window weight function for the 9x9 smoothing block.
// No dependencies; every design file imports this package.
package wws_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RING_ROWS  = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 11;
    localparam int ROW_W      = 11;
    localparam int ERW_W      = 10;
    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int ADDR_W     = RING_W + COL_W;
    localparam int SUM_W      = 17;
    localparam int WSUM_W     = 9;
    localparam int TAP_W      = 4;
    localparam logic [TAP_W-1:0] TAP_LAST = 4'd8;
    localparam logic [TAP_W-1:0] TAP_MID  = 4'd4;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_index;

    // Weight of a tap: 9 minus the Manhattan distance to the window center.
    function automatic logic [TAP_W-1:0] tap_weight(input logic [TAP_W-1:0] dy,
                                                    input logic [TAP_W-1:0] dx);
        logic [TAP_W-1:0] ady;
        logic [TAP_W-1:0] adx;
        ady = (dy >= TAP_MID) ? dy - TAP_MID : TAP_MID - dy;
        adx = (dx >= TAP_MID) ? dx - TAP_MID : TAP_MID - dx;
        return 4'd9 - ady - adx;
    endfunction
endpackage

// ===== design/wws_line_mem.sv =====
// Line store: a ring of sixteen rows, one write port and one registered read port.
// Depends on wws_pkg for the address width.
module wws_line_mem
    import wws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);
    logic [7:0] r_mem [0:(1<<ADDR_W)-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/wws_div.sv =====
// Restoring divider, one quotient bit per cycle, for weighted sum over weight sum.
// Depends on wws_pkg for the operand widths.
module wws_div
    import wws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [WSUM_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [SUM_W-1:0]  o_quotient
);
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [WSUM_W:0]   r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [WSUM_W-1:0] r_dsr;
    logic [WSUM_W:0]   n_shift;

    assign n_shift = {r_rem[WSUM_W-1:0], r_quo[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(SUM_W);
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (n_shift >= {1'b0, r_dsr}) begin
                r_rem <= n_shift - {1'b0, r_dsr};
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;
endmodule

// ===== design/weighted_window_smoothing_9x9.sv =====
// Top level of the normalized 9x9 weighted smoothing filter: counters, sequencer,
// window accumulation and output register. Uses wws_pkg, wws_line_mem and wws_div.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata: pixel; tuser: opcode
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata: filtered,column,line; tlast
//  cfg       in         i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// An item that yields no result passes only through the check state; one that yields
// a result also takes 81 reads of the single line store read port and a 17-step divider.
// i_rst_n is synchronous and active low; it sets both sizes to 1024 and zeroes counters.
// A finished result waits in the output register while the next item is accepted.
// Configuration writes are taken only between items and win over a waiting input item.
module weighted_window_smoothing_9x9
    import wws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic        s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] filtered, [17:8] out_column, [27:18] out_line
    output logic        m_axis_tlast,   // frame_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FLUSH,
        ST_DSTART,
        ST_DIV
    } t_state;

    t_state            r_state;
    logic [DIM_W-1:0]  r_w, r_h;
    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [COL_W-1:0]  r_em_col;
    logic [ERW_W-1:0]  r_em_row;
    logic [TAP_W-1:0]  r_dy, r_dx;
    logic              r_pv;
    logic [TAP_W-1:0]  r_pw;
    logic [SUM_W-1:0]  r_sum;
    logic [WSUM_W-1:0] r_wsum;
    logic              r_out_valid;
    logic [31:0]       r_out_data;
    logic              r_out_last;

    logic              in_acc, cfg_acc, store_px, mem_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0]        rdata;
    logic [DIM_W-1:0]  cfg_eff;
    logic [DIM_W-1:0]  cfg_max;
    logic [DIM_W-1:0]  nr, nc, em_row4, em_col4;
    logic              ready_out, em_last, tap_in;
    logic signed [DIM_W:0] row_s, col_s;
    logic              div_busy;
    logic [SUM_W-1:0]  div_q;
    logic              out_free;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign store_px = in_acc && (t_opcode'(s_axis_tuser) == OP_PIXEL) && (r_in_row < r_h);
    assign mem_we   = store_px;
    assign waddr    = {r_in_row[RING_W-1:0], r_in_col};

    assign cfg_max = (t_reg_index'(i_cfg_index) == REG_WIDTH) ? DIM_W'(MAX_WIDTH)
                                                               : DIM_W'(MAX_HEIGHT);

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_eff = DIM_W'(1);
        end else if (i_cfg_data > cfg_max) begin
            cfg_eff = cfg_max;
        end else begin
            cfg_eff = i_cfg_data;
        end
    end

    // The next output is ready once the pixel at its lower-right window corner, clamped to the image, arrived.
    assign em_row4   = {1'b0, r_em_row} + DIM_W'(4);
    assign em_col4   = {1'b0, r_em_col} + DIM_W'(4);
    assign nr        = (em_row4 > r_h - 1'b1) ? r_h - 1'b1 : em_row4;
    assign nc        = (em_col4 > r_w - 1'b1) ? r_w - 1'b1 : em_col4;
    assign ready_out = (r_in_row > nr) || ((r_in_row == nr) && ({1'b0, r_in_col} > nc));
    assign em_last   = ({1'b0, r_em_row} == r_h - 1'b1) && ({1'b0, r_em_col} == r_w - 1'b1);

    assign row_s  = $signed({2'b00, r_em_row}) + $signed({8'd0, r_dy}) - 12'sd4;
    assign col_s  = $signed({2'b00, r_em_col}) + $signed({8'd0, r_dx}) - 12'sd4;
    assign tap_in = (row_s >= 0) && (row_s < $signed({1'b0, r_h}))
                 && (col_s >= 0) && (col_s < $signed({1'b0, r_w}));
    assign raddr  = {row_s[RING_W-1:0], col_s[COL_W-1:0]};

    wws_line_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    wws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DSTART),
        .i_dividend (r_sum),
        .i_divisor  (r_wsum),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_w         <= DIM_W'(MAX_WIDTH);
            r_h         <= DIM_W'(MAX_HEIGHT);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_em_col    <= '0;
            r_em_row    <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_pv <= (r_state == ST_SCAN) && tap_in;
            r_pw <= tap_weight(r_dy, r_dx);
            if (r_pv) begin
                r_sum  <= r_sum + SUM_W'(r_pw) * SUM_W'(rdata);
                r_wsum <= r_wsum + WSUM_W'(r_pw);
            end

            if (cfg_acc) begin
                if (t_reg_index'(i_cfg_index) == REG_WIDTH) begin
                    r_w <= cfg_eff;
                end else begin
                    r_h <= cfg_eff;
                end
                r_in_col <= '0;
                r_in_row <= '0;
                r_em_col <= '0;
                r_em_row <= '0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (store_px) begin
                            if ({1'b0, r_in_col} + 1'b1 >= r_w) begin
                                r_in_col <= '0;
                                r_in_row <= r_in_row + 1'b1;
                            end else begin
                                r_in_col <= r_in_col + 1'b1;
                            end
                        end
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_sum  <= '0;
                    r_wsum <= '0;
                    r_dy   <= '0;
                    r_dx   <= '0;
                    r_state <= ready_out ? ST_SCAN : ST_IDLE;
                end
                ST_SCAN: begin
                    if (r_dx == TAP_LAST) begin
                        r_dx <= '0;
                        if (r_dy == TAP_LAST) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_dy <= r_dy + 1'b1;
                        end
                    end else begin
                        r_dx <= r_dx + 1'b1;
                    end
                end
                ST_FLUSH: begin
                    r_state <= ST_DSTART;
                end
                ST_DSTART: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (!div_busy && out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'd0, r_em_row, r_em_col, div_q[7:0]};
                        r_out_last  <= em_last;
                        if (em_last) begin
                            r_in_col <= '0;
                            r_in_row <= '0;
                            r_em_col <= '0;
                            r_em_row <= '0;
                        end else if ({1'b0, r_em_col} + 1'b1 >= r_w) begin
                            r_em_col <= '0;
                            r_em_row <= r_em_row + 1'b1;
                        end else begin
                            r_em_col <= r_em_col + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTH
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_in_col} < r_w)
        else $error("input column beyond image width");
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !mem_we)
        else $error("line store written while the window is read");
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !div_busy) |-> (div_q[SUM_W-1:8] == '0))
        else $error("smoothed value exceeds eight bits");
    a_wsum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DSTART) |-> (r_wsum != '0))
        else $error("window weight sum is zero");
`endif
endmodule
